// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Include by bare file name; each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define AST_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds through reset.
`define AST_NEXT_NR(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/fsc_pkg.sv =====
// Package of the suffix frequency counter: request and result types,
// operation codes, register indexes and helpers. No dependencies.
package fsc_pkg;

    localparam int C_MAX_SUFFIX    = 31;
    localparam int C_TABLE_ENTRIES = 64;
    localparam int C_CHAR_W        = 8;
    localparam int C_DATE_W        = 24;

    localparam logic [7:0] C_DOT = 8'h2E;

    localparam logic [1:0] OP_HOST  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic CFG_BEGIN = 1'b0;
    localparam logic CFG_END   = 1'b1;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [C_CHAR_W-1:0] host_char;
        logic                host_last;
        logic [C_DATE_W-1:0] log_date;
        logic [5:0]          entry_index;
    } t_req;

    typedef struct packed {
        logic                counted;
        logic                table_full;
        logic                suffix_truncated;
        logic [31:0]         total_count;
        logic                entry_valid;
        logic [31:0]         entry_count;
        logic [C_CHAR_W-1:0] suffix_char;
        logic                char_last;
    } t_res;

    typedef struct packed {
        logic append;
        logic rotate;
    } t_cell_ctl;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

// ===== design/fsc_cell.sv =====
// One character cell of the suffix chain.
// Depends on fsc_pkg for the cell control struct.
module fsc_cell (
    input  logic                       i_clk,
    input  fsc_pkg::t_cell_ctl         i_ctl,
    input  logic [fsc_pkg::C_CHAR_W-1:0] i_left,
    input  logic [fsc_pkg::C_CHAR_W-1:0] i_right,
    output logic [fsc_pkg::C_CHAR_W-1:0] o_ch
);
    import fsc_pkg::*;

    logic [C_CHAR_W-1:0] r_ch;

    // Append moves characters away from the head; rotate moves them toward it.
    always_ff @(posedge i_clk) begin
        if (i_ctl.append) begin
            r_ch <= i_left;
        end else if (i_ctl.rotate) begin
            r_ch <= i_right;
        end
    end

    assign o_ch = r_ch;
endmodule

// ===== design/fsc_chain.sv =====
// Row of character cells that holds the suffix in progress.
// Depends on fsc_pkg and fsc_cell.
module fsc_chain #(
    parameter int P_CELLS = fsc_pkg::C_MAX_SUFFIX
) (
    input  logic                         i_clk,
    input  fsc_pkg::t_cell_ctl           i_ctl,
    input  logic [fsc_pkg::C_CHAR_W-1:0] i_char,
    output logic [fsc_pkg::C_CHAR_W-1:0] o_head
);
    import fsc_pkg::*;

    logic [C_CHAR_W-1:0] q [P_CELLS];

    for (genvar k = 0; k < P_CELLS; k++) begin : g_cell
        fsc_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (i_ctl),
            .i_left ((k == 0) ? i_char : q[(k + P_CELLS - 1) % P_CELLS]),
            .i_right(q[(k + 1) % P_CELLS]),
            .o_ch   (q[k])
        );
    end

    // The newest character sits at the head; rotation closes the ring.
    assign o_head = q[0];
endmodule

// ===== design/tld_frequency_counter_core.sv =====
// Top level of the suffix frequency counter: control, table memories, registers.
// Depends on fsc_pkg and fsc_chain.
//
// A hostname byte that is not the last gives no result. On a last byte whose log date
// lies in the configured window, the block walks the table one entry at a time: an
// entry of another length is passed over after its length check, and one of equal
// length has its text compared one character a cycle while the suffix ring turns
// once; if none matches and the table has room, a new entry is added as the ring
// turns once more. A read of a used entry gives its characters on consecutive cycles.
// busy is high while a request is in progress; results cannot be held off, and each
// is shown for one cycle with o_result_valid. The table needs no clearing pass.
module tld_frequency_counter_core #(
    parameter int P_MAX_SUFFIX    = fsc_pkg::C_MAX_SUFFIX,
    parameter int P_TABLE_ENTRIES = fsc_pkg::C_TABLE_ENTRIES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  fsc_pkg::t_req                i_req,
    output logic                         o_result_valid,
    output fsc_pkg::t_res                o_res,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [fsc_pkg::C_DATE_W-1:0] i_cfg_data
);
    import fsc_pkg::*;

    localparam int LW    = $clog2(P_MAX_SUFFIX + 1);
    localparam int EW    = $clog2(P_TABLE_ENTRIES + 1);
    localparam int IW    = $clog2(P_TABLE_ENTRIES);
    localparam int DEPTH = P_TABLE_ENTRIES * P_MAX_SUFFIX;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LEN  = 4'd1;
    localparam logic [3:0] S_LCHK = 4'd2;
    localparam logic [3:0] S_CMP  = 4'd3;
    localparam logic [3:0] S_CEND = 4'd4;
    localparam logic [3:0] S_ADD  = 4'd5;
    localparam logic [3:0] S_RDCK = 4'd6;
    localparam logic [3:0] S_RDST = 4'd7;

    logic [C_CHAR_W-1:0] mem_text  [DEPTH];
    logic [LW-1:0]       mem_len   [P_TABLE_ENTRIES];
    logic [31:0]         mem_tally [P_TABLE_ENTRIES];

    logic [3:0]          r_state, n_state;
    logic [LW-1:0]       r_len, n_len;
    logic                r_trunc, n_trunc;
    logic                r_trunc_hold, n_trunc_hold;
    logic [EW-1:0]       r_used, n_used;
    logic [31:0]         r_total, n_total;
    logic [C_DATE_W-1:0] r_begin, r_end;
    logic [EW-1:0]       r_e, n_e;
    logic [AW-1:0]       r_base, n_base;
    logic [LW-1:0]       r_j, n_j;
    logic                r_pend, n_pend;
    logic                r_mis, n_mis;
    logic [C_CHAR_W-1:0] r_head, n_head;
    t_res                r_res, n_res;
    logic                r_res_vld, n_res_vld;
    logic [C_CHAR_W-1:0] r_txt_q;
    logic [LW-1:0]       r_len_q;
    logic [31:0]         r_tally_q;

    t_cell_ctl           ctl;
    logic [C_CHAR_W-1:0] head;
    logic                txt_we, txt_re, meta_re, len_we, tally_we;
    logic [AW-1:0]       txt_waddr, txt_raddr;
    logic [C_CHAR_W-1:0] txt_wdata;
    logic [IW-1:0]       meta_addr;
    logic [31:0]         tally_wdata;
    logic [LW-1:0]       ridx;
    logic                in_range, mis_now;

    fsc_chain #(.P_CELLS(P_MAX_SUFFIX)) u_chain (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_char(i_req.host_char),
        .o_head(head)
    );

    // Position of the character at the ring head during a compare or copy pass.
    assign ridx     = r_len - LW'(1) - r_j;
    assign in_range = (i_req.log_date >= r_begin) && (i_req.log_date <= r_end);
    assign mis_now  = r_mis || (r_pend && (r_txt_q != r_head));
    assign busy     = (r_state != S_IDLE);

    function automatic t_res mk_res(input logic cnt, input logic full, input logic trn,
                                    input logic [31:0] tot, input logic vld,
                                    input logic [31:0] ecnt,
                                    input logic [C_CHAR_W-1:0] ch, input logic lst);
        t_res r;
        r.counted          = cnt;
        r.table_full       = full;
        r.suffix_truncated = trn;
        r.total_count      = tot;
        r.entry_valid      = vld;
        r.entry_count      = ecnt;
        r.suffix_char      = ch;
        r.char_last        = lst;
        return r;
    endfunction

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_trunc      = r_trunc;
        n_trunc_hold = r_trunc_hold;
        n_used       = r_used;
        n_total      = r_total;
        n_e          = r_e;
        n_base       = r_base;
        n_j          = r_j;
        n_pend       = r_pend;
        n_mis        = r_mis;
        n_head       = r_head;
        n_res        = r_res;
        n_res_vld    = 1'b0;
        ctl          = '0;
        txt_we       = 1'b0;
        txt_re       = 1'b0;
        meta_re      = 1'b0;
        len_we       = 1'b0;
        tally_we     = 1'b0;
        txt_waddr    = r_base + AW'(ridx);
        txt_raddr    = r_base + AW'(ridx);
        txt_wdata    = head;
        meta_addr    = IW'(r_e);
        tally_wdata  = sat_inc32(r_tally_q);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_req.opcode)
                        OP_HOST: begin
                            if (i_req.host_char == C_DOT) begin
                                n_len   = '0;
                                n_trunc = 1'b0;
                            end else if (r_len < LW'(P_MAX_SUFFIX)) begin
                                ctl.append = 1'b1;
                                n_len      = r_len + LW'(1);
                            end else begin
                                n_trunc = 1'b1;
                            end
                            if (i_req.host_last) begin
                                n_trunc_hold = n_trunc;
                                n_e          = '0;
                                n_base       = '0;
                                if (in_range) begin
                                    n_state = S_LEN;
                                end else begin
                                    n_res_vld = 1'b1;
                                    n_res     = mk_res(1'b0, 1'b0, n_trunc, r_total,
                                                       1'b0, 32'd0, '0, 1'b1);
                                    n_len     = '0;
                                    n_trunc   = 1'b0;
                                end
                            end
                        end
                        OP_READ: begin
                            if (32'(i_req.entry_index) >= 32'(r_used)) begin
                                n_res_vld = 1'b1;
                                n_res     = mk_res(1'b0, 1'b0, 1'b0, r_total,
                                                   1'b0, 32'd0, '0, 1'b1);
                            end else begin
                                meta_re   = 1'b1;
                                meta_addr = IW'(i_req.entry_index);
                                n_base    = AW'(32'(i_req.entry_index) * P_MAX_SUFFIX);
                                n_state   = S_RDCK;
                            end
                        end
                        OP_CLEAR: begin
                            n_used    = '0;
                            n_total   = 32'd0;
                            n_res_vld = 1'b1;
                            n_res     = mk_res(1'b0, 1'b0, 1'b0, 32'd0,
                                               1'b0, 32'd0, '0, 1'b1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LEN: begin
                if (r_e == r_used) begin
                    if (r_used >= EW'(P_TABLE_ENTRIES)) begin
                        n_res_vld = 1'b1;
                        n_res     = mk_res(1'b0, 1'b1, r_trunc_hold, r_total,
                                           1'b0, 32'd0, '0, 1'b1);
                        n_len     = '0;
                        n_trunc   = 1'b0;
                        n_state   = S_IDLE;
                    end else begin
                        n_j     = '0;
                        n_state = S_ADD;
                    end
                end else begin
                    meta_re = 1'b1;
                    n_state = S_LCHK;
                end
            end
            S_LCHK: begin
                if (r_len_q == r_len) begin
                    n_j     = '0;
                    n_mis   = 1'b0;
                    n_pend  = 1'b0;
                    n_state = S_CMP;
                end else begin
                    n_e     = r_e + EW'(1);
                    n_base  = r_base + AW'(P_MAX_SUFFIX);
                    n_state = S_LEN;
                end
            end
            S_CMP: begin
                // One full turn of the ring compares the suffix from its last
                // character back to its first and leaves the ring as it was.
                ctl.rotate = 1'b1;
                n_mis      = mis_now;
                if (r_j < r_len) begin
                    txt_re = 1'b1;
                    n_head = head;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                n_j = r_j + LW'(1);
                if (r_j == LW'(P_MAX_SUFFIX - 1)) begin
                    n_state = S_CEND;
                end
            end
            S_CEND: begin
                n_pend = 1'b0;
                if (!mis_now) begin
                    tally_we  = 1'b1;
                    n_total   = sat_inc32(r_total);
                    n_res_vld = 1'b1;
                    n_res     = mk_res(1'b1, 1'b0, r_trunc_hold, sat_inc32(r_total),
                                       1'b0, 32'd0, '0, 1'b1);
                    n_len     = '0;
                    n_trunc   = 1'b0;
                    n_state   = S_IDLE;
                end else begin
                    n_e     = r_e + EW'(1);
                    n_base  = r_base + AW'(P_MAX_SUFFIX);
                    n_state = S_LEN;
                end
            end
            S_ADD: begin
                ctl.rotate = 1'b1;
                txt_we     = (r_j < r_len);
                n_j        = r_j + LW'(1);
                if (r_j == LW'(P_MAX_SUFFIX - 1)) begin
                    len_we      = 1'b1;
                    tally_we    = 1'b1;
                    tally_wdata = 32'd1;
                    n_used      = r_used + EW'(1);
                    n_total     = sat_inc32(r_total);
                    n_res_vld   = 1'b1;
                    n_res       = mk_res(1'b1, 1'b0, r_trunc_hold, sat_inc32(r_total),
                                         1'b0, 32'd0, '0, 1'b1);
                    n_len       = '0;
                    n_trunc     = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            S_RDCK: begin
                if (r_len_q == '0) begin
                    n_res_vld = 1'b1;
                    n_res     = mk_res(1'b0, 1'b0, 1'b0, r_total,
                                       1'b1, r_tally_q, '0, 1'b1);
                    n_state   = S_IDLE;
                end else begin
                    n_j     = '0;
                    n_pend  = 1'b0;
                    n_state = S_RDST;
                end
            end
            S_RDST: begin
                txt_raddr = r_base + AW'(r_j);
                if (r_j < r_len_q) begin
                    txt_re = 1'b1;
                    n_pend = 1'b1;
                    n_j    = r_j + LW'(1);
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    n_res_vld = 1'b1;
                    n_res     = mk_res(1'b0, 1'b0, 1'b0, r_total, 1'b1, r_tally_q,
                                       r_txt_q, (r_j == r_len_q));
                    if (r_j == r_len_q) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (txt_we) begin
            mem_text[txt_waddr] <= txt_wdata;
        end
        if (txt_re) begin
            r_txt_q <= mem_text[txt_raddr];
        end
        if (len_we) begin
            mem_len[meta_addr] <= r_len;
        end
        if (tally_we) begin
            mem_tally[meta_addr] <= tally_wdata;
        end
        if (meta_re) begin
            r_len_q   <= mem_len[meta_addr];
            r_tally_q <= mem_tally[meta_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_trunc   <= 1'b0;
            r_used    <= '0;
            r_total   <= 32'd0;
            r_begin   <= '0;
            r_end     <= '1;
            r_res_vld <= 1'b0;
            r_pend    <= 1'b0;
            r_mis     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_trunc   <= n_trunc;
            r_used    <= n_used;
            r_total   <= n_total;
            r_res_vld <= n_res_vld;
            r_pend    <= n_pend;
            r_mis     <= n_mis;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BEGIN: r_begin <= i_cfg_data;
                    CFG_END:   r_end   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_trunc_hold <= n_trunc_hold;
        r_e          <= n_e;
        r_base       <= n_base;
        r_j          <= n_j;
        r_head       <= n_head;
        r_res        <= n_res;
    end

    assign o_result_valid = r_res_vld;
    assign o_res          = r_res;
endmodule

// ===== design/fsc_checker.sv =====
// Port-level checks of the suffix frequency counter, bound to its top level.
// Depends on fsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fsc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input fsc_pkg::t_req i_req,
    input logic          o_result_valid,
    input fsc_pkg::t_res o_res
);
    import fsc_pkg::*;

    // A clear request answers in the next cycle with an empty total.
    `AST_NEXT(a_clear_resp, i_clk, i_rst_n, start && !busy && i_req.opcode == OP_CLEAR, o_result_valid && o_res.total_count == 32'd0 && o_res.char_last)
    // A host is never both counted and rejected for a full table.
    `AST_SAME(a_cnt_full, i_clk, i_rst_n, o_result_valid, !(o_res.counted && o_res.table_full))
    // Read characters follow one another without gaps until the last one.
    `AST_NEXT(a_stream, i_clk, i_rst_n, o_result_valid && !o_res.char_last, o_result_valid)
    // Reset leaves the block idle with no result pending.
    `AST_NEXT_NR(a_reset, i_clk, !i_rst_n, !busy && !o_result_valid)
endmodule

bind tld_frequency_counter_core fsc_checker u_fsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_req         (i_req),
    .o_result_valid(o_result_valid),
    .o_res         (o_res)
);

// ===== verif/tld_frequency_counter_core_tb.sv =====
// Self-checking testbench of tld_frequency_counter_core: a directed table, then random
// hostnames, reads and clears, checked against an in-bench suffix counting predictor.
// Depends on fsc_pkg and the RTL of the core.
module tld_frequency_counter_core_tb;
    import fsc_pkg::*;

    localparam int MAX_CYCLES = 3_000_000;

    typedef logic [7:0] t_chars[$];

    typedef struct {
        t_req req;
        bit   typed;
        t_res res;
    } t_row;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_req   i_req = '0;
    logic   o_result_valid;
    t_res   o_res;
    logic   i_cfg_we = 1'b0;
    logic   i_cfg_idx = CFG_BEGIN;
    logic   [C_DATE_W-1:0] i_cfg_data = '0;

    // Predictor state.
    logic [C_DATE_W-1:0] date_lo = '0;
    logic [C_DATE_W-1:0] date_hi = '1;
    logic [7:0]  cur_text[C_MAX_SUFFIX];
    int          cur_len = 0;
    bit          cur_trunc = 0;
    logic [7:0]  tld_text[C_TABLE_ENTRIES][C_MAX_SUFFIX];
    int          tld_len[C_TABLE_ENTRIES];
    logic [31:0] tld_tally[C_TABLE_ENTRIES];
    int          tlds_used = 0;
    logic [31:0] hosts_counted = '0;

    t_res   expected_q[$];
    int     fail_count = 0;
    int     results_seen = 0;
    int     cycle_count = 0;
    bit     no_idle = 0;

    tld_frequency_counter_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_result_valid(o_result_valid), .o_res(o_res), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_req mk_req(logic [1:0] op, logic [7:0] ch, logic last,
                                    logic [23:0] date, logic [5:0] idx);
        t_req r;
        r.opcode = op;
        r.host_char = ch;
        r.host_last = last;
        r.log_date = date;
        r.entry_index = idx;
        return r;
    endfunction

    function automatic t_res mk_res(logic cnt, logic full, logic trunc, logic [31:0] tot,
                                    logic valid, logic [31:0] ecnt, logic [7:0] ch,
                                    logic last);
        t_res r;
        r.counted = cnt;
        r.table_full = full;
        r.suffix_truncated = trunc;
        r.total_count = tot;
        r.entry_valid = valid;
        r.entry_count = ecnt;
        r.suffix_char = ch;
        r.char_last = last;
        return r;
    endfunction

    // Returns 1 when counted, 0 when the date is out of range, 2 when the table is full.
    function automatic int tally_suffix(logic [23:0] date);
        bit same;
        if (date < date_lo || date > date_hi) return 0;
        for (int e = 0; e < tlds_used; e++) begin
            if (tld_len[e] == cur_len) begin
                same = 1;
                for (int i = 0; i < cur_len; i++)
                    if (tld_text[e][i] !== cur_text[i]) same = 0;
                if (same) begin
                    if (tld_tally[e] != 32'hFFFF_FFFF) tld_tally[e] = tld_tally[e] + 1;
                    return 1;
                end
            end
        end
        if (tlds_used >= C_TABLE_ENTRIES) return 2;
        for (int i = 0; i < cur_len; i++) tld_text[tlds_used][i] = cur_text[i];
        tld_len[tlds_used] = cur_len;
        tld_tally[tlds_used] = 1;
        tlds_used++;
        return 1;
    endfunction

    function automatic void predict_request(t_req r);
        int outcome;
        int idx;
        if (r.opcode == OP_HOST) begin
            if (r.host_char == C_DOT) begin
                cur_len = 0;
                cur_trunc = 0;
            end else if (cur_len < C_MAX_SUFFIX) begin
                cur_text[cur_len] = r.host_char;
                cur_len++;
            end else begin
                cur_trunc = 1;
            end
            if (!r.host_last) return;
            outcome = tally_suffix(r.log_date);
            if (outcome == 1 && hosts_counted != 32'hFFFF_FFFF) hosts_counted++;
            expected_q.push_back(mk_res(outcome == 1, outcome == 2, cur_trunc,
                                        hosts_counted, 0, 0, 0, 1));
            cur_len = 0;
            cur_trunc = 0;
        end else if (r.opcode == OP_READ) begin
            idx = r.entry_index;
            if (idx >= tlds_used)
                expected_q.push_back(mk_res(0, 0, 0, hosts_counted, 0, 0, 0, 1));
            else if (tld_len[idx] == 0)
                expected_q.push_back(mk_res(0, 0, 0, hosts_counted, 1, tld_tally[idx], 0, 1));
            else
                for (int i = 0; i < tld_len[idx]; i++)
                    expected_q.push_back(mk_res(0, 0, 0, hosts_counted, 1, tld_tally[idx],
                                                tld_text[idx][i], i == tld_len[idx] - 1));
        end else if (r.opcode == OP_CLEAR) begin
            tlds_used = 0;
            hosts_counted = 0;
            expected_q.push_back(mk_res(0, 0, 0, 0, 0, 0, 0, 1));
        end
    endfunction

    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && o_result_valid) begin
            results_seen <= results_seen + 1;
            if (expected_q.size() == 0) begin
                $error("unexpected result %p", o_res);
                fail_count++;
            end else begin
                exp_res = expected_q.pop_front();
                if (o_res.counted !== exp_res.counted) begin
                    $error("counted: expected %0d, got %0d", exp_res.counted, o_res.counted);
                    fail_count++;
                end
                if (o_res.table_full !== exp_res.table_full) begin
                    $error("table_full: expected %0d, got %0d",
                           exp_res.table_full, o_res.table_full);
                    fail_count++;
                end
                if (o_res.suffix_truncated !== exp_res.suffix_truncated) begin
                    $error("suffix_truncated: expected %0d, got %0d",
                           exp_res.suffix_truncated, o_res.suffix_truncated);
                    fail_count++;
                end
                if (o_res.total_count !== exp_res.total_count) begin
                    $error("total_count: expected %0d, got %0d",
                           exp_res.total_count, o_res.total_count);
                    fail_count++;
                end
                if (o_res.entry_valid !== exp_res.entry_valid) begin
                    $error("entry_valid: expected %0d, got %0d",
                           exp_res.entry_valid, o_res.entry_valid);
                    fail_count++;
                end
                if (o_res.entry_count !== exp_res.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           exp_res.entry_count, o_res.entry_count);
                    fail_count++;
                end
                if (o_res.suffix_char !== exp_res.suffix_char) begin
                    $error("suffix_char: expected %0h, got %0h",
                           exp_res.suffix_char, o_res.suffix_char);
                    fail_count++;
                end
                if (o_res.char_last !== exp_res.char_last) begin
                    $error("char_last: expected %0d, got %0d",
                           exp_res.char_last, o_res.char_last);
                    fail_count++;
                end
            end
        end
    end

    // Busy is sampled right after the edge, so it still shows the value that the
    // block used to decide whether the request was taken.
    task automatic send_request(t_req r);
        if (!no_idle && $urandom_range(99) < 13) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        predict_request(r);
    endtask

    function automatic logic [23:0] pick_date();
        if ($urandom_range(99) < 85) return $urandom_range(date_hi, date_lo);
        return $urandom_range(24'hFF_FFFF, 0);
    endfunction

    task automatic send_host(t_chars chars);
        logic [23:0] date;
        date = pick_date();
        foreach (chars[i]) begin
            // Now and then a read slips in while a hostname is half sent.
            if (i > 0 && $urandom_range(99) < 3)
                send_request(mk_req(OP_READ, 0, 0, 0, $urandom_range(63)));
            send_request(mk_req(OP_HOST, chars[i], i == chars.size() - 1,
                                i == chars.size() - 1 ? date : $urandom_range(24'hFF_FFFF, 0),
                                $urandom_range(63)));
        end
    endtask

    function automatic logic [7:0] rand_char();
        logic [7:0] c;
        do c = $urandom_range(255); while (c == C_DOT);
        return c;
    endfunction

    function automatic t_chars rand_host();
        t_chars h;
        int pool;
        int sfx_len;
        repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(1, 3)) h.push_back(rand_char());
            h.push_back(C_DOT);
        end
        pool = $urandom_range(99);
        if (pool < 60) begin
            // A small set of common suffixes so that entries get incremented.
            case ($urandom_range(3))
                0: h = {h, "c", "o", "m"};
                1: h = {h, "o", "r", "g"};
                2: h = {h, "d", "e"};
                default: h = {h, "C", "o", "m"};
            endcase
        end else begin
            sfx_len = (pool < 70) ? $urandom_range(31, 40)
                    : (pool < 73) ? 0 : $urandom_range(1, 4);
            repeat (sfx_len) h.push_back(rand_char());
        end
        if (h.size() == 0) h.push_back(C_DOT);
        return h;
    endfunction

    task automatic write_reg(logic idx, logic [23:0] value);
        start <= 1'b0;
        wait (expected_q.size() == 0);
        do @(posedge i_clk); while (busy);
        repeat (40) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BEGIN) date_lo = value;
        else date_hi = value;
    endtask

    task automatic random_mix(int hosts);
        int pick;
        for (int n = 0; n < hosts; n++) begin
            pick = $urandom_range(99);
            if (pick < 78) send_host(rand_host());
            else if (pick < 90)
                send_request(mk_req(OP_READ, $urandom_range(255), $urandom_range(1),
                                    $urandom_range(24'hFF_FFFF, 0),
                                    tlds_used > 0 && pick < 86 ?
                                    $urandom_range(tlds_used - 1) : $urandom_range(63)));
            else if (pick < 94) send_request(mk_req(OP_CLEAR, 0, 0, 0, 0));
            else send_request(mk_req(2'd3, $urandom_range(255), $urandom_range(1),
                                     $urandom_range(24'hFF_FFFF, 0), $urandom_range(63)));
        end
    endtask

    initial begin
        t_row rows[$];
        t_chars h;
        rows = '{
            '{mk_req(OP_READ, 0, 0, 0, 6'd5), 1, mk_res(0, 0, 0, 0, 0, 0, 0, 1)},
            '{mk_req(OP_CLEAR, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, 0, 0, 0, 1)},
            '{mk_req(OP_HOST, "a", 0, 0, 0), 0, '0},
            '{mk_req(OP_HOST, C_DOT, 0, 0, 0), 0, '0},
            '{mk_req(OP_HOST, "c", 0, 0, 0), 0, '0},
            '{mk_req(OP_HOST, "o", 0, 0, 0), 0, '0},
            '{mk_req(OP_HOST, "m", 1, 24'd0, 0), 0, '0},
            '{mk_req(OP_HOST, "c", 0, 0, 0), 0, '0},
            '{mk_req(OP_HOST, "o", 0, 0, 0), 0, '0},
            '{mk_req(OP_HOST, "m", 1, 24'hFF_FFFF, 0), 0, '0},
            '{mk_req(OP_HOST, "x", 0, 0, 0), 0, '0},
            '{mk_req(OP_HOST, C_DOT, 1, 24'h12_3456, 0), 0, '0},
            '{mk_req(OP_HOST, 8'hFF, 1, 24'hFF_FFFF, 6'h3F), 0, '0},
            '{mk_req(OP_HOST, 8'h00, 1, 24'h00_0000, 6'h00), 0, '0},
            '{mk_req(2'd3, 8'hFF, 1, 24'hFF_FFFF, 6'h3F), 0, '0},
            '{mk_req(OP_READ, 0, 0, 0, 6'd0), 0, '0},
            '{mk_req(OP_READ, 0, 0, 0, 6'd1), 0, '0},
            '{mk_req(OP_READ, 0, 0, 0, 6'd2), 0, '0},
            '{mk_req(OP_READ, 0, 0, 0, 6'd3), 0, '0},
            '{mk_req(OP_READ, 8'hFF, 1, 24'hFF_FFFF, 6'h3F), 0, '0},
            '{mk_req(OP_CLEAR, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, 0, 0, 0, 1)},
            '{mk_req(OP_READ, 0, 0, 0, 6'd0), 1, mk_res(0, 0, 0, 0, 0, 0, 0, 1)}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_request(rows[i].req);
            if (rows[i].typed) expected_q[expected_q.size() - 1] = rows[i].res;
        end

        write_reg(CFG_END, 24'hFF_FFFF);
        write_reg(CFG_BEGIN, 24'h00_0000);
        random_mix(4);

        write_reg(CFG_BEGIN, 24'h00_0100);
        write_reg(CFG_END, 24'h00_0200);
        random_mix(2);
        write_reg(CFG_BEGIN, 24'hFF_FFFF);
        write_reg(CFG_END, 24'hFF_FFFF);
        random_mix(2);
        write_reg(CFG_BEGIN, 24'h00_0000);
        write_reg(CFG_END, 24'h00_0000);
        random_mix(1);
        write_reg(CFG_END, 24'hFF_FFFF);

        // Fill the table with distinct one-character suffixes until it overflows,
        // with no idling during this stretch.
        send_request(mk_req(OP_CLEAR, 0, 0, 0, 0));
        no_idle = 1;
        for (int n = 0; n < C_TABLE_ENTRIES + 3; n++) begin
            h = '{8'(n + 128)};
            send_host(h);
        end
        no_idle = 0;
        random_mix(1);
        for (int n = 0; n < C_TABLE_ENTRIES; n += 9)
            send_request(mk_req(OP_READ, 0, 0, 0, 6'(n)));
        send_request(mk_req(OP_READ, 0, 0, 0, 6'h3F));

        start <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (3000) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_q.size());
            fail_count++;
        end
        $display("Checked %0d results over directed rows, several date windows,", results_seen);
        $display("suffix truncation, empty suffixes, reads, clears and a full table.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
